// ===== rtl/core/afu_pkg.sv =====
// ----------------------------------------------------------------------------
// afu_pkg
// Shared types and constants for the stereo frame FIFO and 2:3 upsampler.
// ----------------------------------------------------------------------------
package afu_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FRAME_W   = 2 * SAMPLE_W;
  localparam int unsigned LIMIT_W   = 14;
  localparam int unsigned BUFFERED_W = 14;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd6000;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_FRAME    = 2'd3
  } status_e;

  typedef struct packed {
    logic                        first_of_call;
    op_e                         opcode;
    logic signed [SAMPLE_W-1:0]  left_in;
    logic signed [SAMPLE_W-1:0]  right_in;
  } item_t;

  typedef struct packed {
    status_e                     status;
    logic signed [SAMPLE_W-1:0]  left_out;
    logic signed [SAMPLE_W-1:0]  right_out;
    logic                        block_end;
    logic [BUFFERED_W-1:0]       buffered_frames;
  } result_t;

endpackage

// ===== rtl/core/afu_ram.sv =====
// ----------------------------------------------------------------------------
// afu_ram
// Frame store: one write port, one registered read port, write-to-read bypass.
// ----------------------------------------------------------------------------
module afu_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q  <= mem_q[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // array read returns old contents on a same-address write; take the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_data_q;

endmodule

// ===== rtl/core/afu_ctrl.sv =====
// ----------------------------------------------------------------------------
// afu_ctrl
// FIFO bookkeeping, admission, grant and upsampler phase; one item per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module afu_ctrl #(
  parameter int unsigned FIFO_DEPTH       = 8192,
  parameter int unsigned OUT_BLOCK_FRAMES = 256,
  parameter int unsigned IN_BLOCK_FRAMES  = 171,
  parameter int unsigned AW               = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  afu_pkg::item_t                  item_i,
  input  logic [afu_pkg::LIMIT_W-1:0]     limit_i,
  input  logic [afu_pkg::FRAME_W-1:0]     head_i,
  output afu_pkg::result_t                result_o,
  output logic                            wr_en_o,
  output logic [AW-1:0]                   wr_addr_o,
  output logic [afu_pkg::FRAME_W-1:0]     wr_data_o,
  output logic [AW-1:0]                   rd_addr_o
);
  import afu_pkg::*;

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned GW    = $clog2(IN_BLOCK_FRAMES + 1);
  localparam int unsigned PW    = $clog2(OUT_BLOCK_FRAMES);

  logic [AW-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]   bc_q, bc_d, sc_q, sc_d;
  logic [PW-1:0]      phase_q, phase_d;
  logic [1:0]         mod3_q, mod3_d;
  logic [GW-1:0]      gl_q, gl_d;
  logic [FRAME_W-1:0] held_q, held_d;
  logic               adm_q, adm_d;

  logic [CNT_W+LIMIT_W-1:0] bc_ext, lim_ext;
  logic [CNT_W+BUFFERED_W-1:0] bc_out_ext;
  logic [GW-1:0]      grant, gl_eff, adv;
  logic               pop, blk_end, admitted;
  logic [AW:0]        rp_sum;
  logic [FRAME_W-1:0] frame;

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    bc_d    = bc_q;
    sc_d    = sc_q;
    phase_d = phase_q;
    mod3_d  = mod3_q;
    gl_d    = gl_q;
    held_d  = held_q;
    adm_d   = adm_q;
    wr_en_o = 1'b0;
    frame   = '0;
    blk_end = 1'b0;
    pop     = 1'b0;
    adv     = '0;
    rp_sum  = '0;

    bc_ext  = {{LIMIT_W{1'b0}}, bc_q};
    lim_ext = {{CNT_W{1'b0}}, limit_i};
    grant   = (bc_q < CNT_W'(IN_BLOCK_FRAMES)) ? bc_q[GW-1:0] : GW'(IN_BLOCK_FRAMES);
    gl_eff  = (phase_q == '0) ? grant : gl_q;
    admitted = item_i.first_of_call ? (bc_ext < lim_ext) : adm_q;

    result_o.status = ST_FRAME;

    if (item_i.opcode == OP_PUSH) begin
      if (!admitted) begin
        result_o.status = ST_REFUSED;
      end else if (sc_q == CNT_W'(FIFO_DEPTH)) begin
        result_o.status = ST_DROPPED;
      end else begin
        result_o.status = ST_ACCEPTED;
        wr_en_o = fire_i;
        wp_d = (wp_q == AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        sc_d = sc_q + 1'b1;
        bc_d = bc_q + 1'b1;
      end
      adm_d = admitted;
    end else begin
      if (phase_q == '0) begin
        bc_d = bc_q - CNT_W'(grant);
      end
      // frame index floor(2p/3) moves on except where p mod 3 is one
      if (mod3_q != 2'd1) begin
        pop    = (gl_eff != '0);
        held_d = pop ? head_i : '0;
      end
      frame   = held_d;
      blk_end = (phase_q == PW'(OUT_BLOCK_FRAMES - 1));
      // at block end the rest of the grant is thrown away with the pop
      adv     = blk_end ? gl_eff : GW'(pop);
      gl_d    = gl_eff - adv;
      rp_sum  = {1'b0, rp_q} + (AW+1)'(adv);
      rp_d    = (rp_sum >= (AW+1)'(FIFO_DEPTH)) ? AW'(rp_sum - (AW+1)'(FIFO_DEPTH))
                                                : rp_sum[AW-1:0];
      sc_d    = sc_q - CNT_W'(adv);
      if (blk_end) begin
        phase_d = '0;
        mod3_d  = 2'd0;
      end else begin
        phase_d = phase_q + 1'b1;
        mod3_d  = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
      end
    end

    if (!fire_i) begin
      rp_d = rp_q;
    end

    bc_out_ext = {{BUFFERED_W{1'b0}}, bc_d};
    result_o.left_out        = frame[SAMPLE_W-1:0];
    result_o.right_out       = frame[FRAME_W-1:SAMPLE_W];
    result_o.block_end       = blk_end;
    result_o.buffered_frames = bc_out_ext[BUFFERED_W-1:0];
  end

  assign wr_addr_o = wp_q;
  assign wr_data_o = {item_i.right_in, item_i.left_in};
  assign rd_addr_o = rp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      bc_q    <= '0;
      sc_q    <= '0;
      phase_q <= '0;
      mod3_q  <= '0;
      gl_q    <= '0;
      held_q  <= '0;
      adm_q   <= 1'b0;
    end else if (fire_i) begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      bc_q    <= bc_d;
      sc_q    <= sc_d;
      phase_q <= phase_d;
      mod3_q  <= mod3_d;
      gl_q    <= gl_d;
      held_q  <= held_d;
      adm_q   <= adm_d;
    end
  end

endmodule

// ===== rtl/core/audio_fifo_upsampler_2to3_top.sv =====
// ----------------------------------------------------------------------------
// audio_fifo_upsampler_2to3_top
// Stereo Q1.15 frame FIFO feeding a 2:3 nearest-neighbour upsampler.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: each transaction is a push (one stereo frame) or an output
//    tick, chosen by tuser[0]; tuser[1] flags the first frame of a push call,
//    where admission against the admission limit is decided for the call.
//  - Master stream: exactly one result transaction per input transaction, in
//    order. tuser carries the status, tlast marks the last frame of a
//    256-frame output block, tdata the samples and the buffered frame count.
//  - Config channel: writes the admission limit; always ready. Write it only
//    while no transaction is in flight.
//  - Path: input register, then the update stage into the result register.
//    Throughput: one transaction per cycle while the receiver does not stall;
//    the frame store read is prefetched at the next read pointer so a pop
//    never waits on the memory port.
//  - Reset: counters, pointers, phase and grant clear; limit returns to 6000.
//    The frame store is not cleared: entries are only read once written.
//  - Receiver stall: the result register holds; the input register fills,
//    then tready drops until the master side takes its transaction.
// ----------------------------------------------------------------------------
module audio_fifo_upsampler_2to3_top #(
  parameter int unsigned FIFO_DEPTH       = 8192,
  parameter int unsigned OUT_BLOCK_FRAMES = 256,
  parameter int unsigned IN_BLOCK_FRAMES  = 171
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // left_in[15:0], right_in[31:16]
  input  logic [1:0]  s_axis_tuser,   // opcode[0], first_of_call[1]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // left_out[15:0], right_out[31:16],
                                      // buffered_frames[45:32], zero pad
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast,   // block_end
  // configuration: admission limit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i
);
  import afu_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  item_t              in_q;
  logic               in_valid_q;
  result_t            res, out_q;
  logic               out_valid_q;
  logic               fire;
  logic [LIMIT_W-1:0] limit_q;

  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [FRAME_W-1:0] wr_data, head;

  // update stage fires when an item waits and the result register is free or being emptied
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.opcode        <= op_e'(s_axis_tuser[0]);
      in_q.first_of_call <= s_axis_tuser[1];
      in_q.left_in       <= s_axis_tdata[15:0];
      in_q.right_in      <= s_axis_tdata[31:16];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  afu_ctrl #(
    .FIFO_DEPTH       (FIFO_DEPTH),
    .OUT_BLOCK_FRAMES (OUT_BLOCK_FRAMES),
    .IN_BLOCK_FRAMES  (IN_BLOCK_FRAMES),
    .AW               (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .limit_i   (limit_q),
    .head_i    (head),
    .result_o  (res),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr)
  );

  afu_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW),
    .DW    (FRAME_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (head)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.buffered_frames, out_q.right_out, out_q.left_out};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.block_end;

endmodule

// ===== test/tb_audio_fifo_upsampler_2to3_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_fifo_upsampler_2to3_top
// Self-checking bench for the stereo frame FIFO with 2:3 upsampler.
// A scoreboard class mirrors the FIFO counts, admission, block grant and
// nearest-neighbour readout, and queues one expected result per accepted
// input transaction. Stimulus: a short directed run, then mixed push calls
// and tick bursts under several idling and admission-limit settings, and a
// long receiver hold-off while the sender keeps offering.
// ----------------------------------------------------------------------------
module tb_audio_fifo_upsampler_2to3_top;
  import afu_pkg::*;

  localparam int unsigned DEPTH      = 8192;
  localparam int unsigned BLOCK_OUT  = 256;
  localparam int unsigned GRANT_MAX  = 171;
  localparam int unsigned LIMIT_MAX  = 8192;
  localparam int unsigned DRAIN_WAIT = 4;    // margin past the input and result registers

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each result from its own copy of the block state
  // --------------------------------------------------------------------------
  class upsampler_scoreboard;
    logic [31:0] frame_mem [0:DEPTH-1];
    logic [12:0] wr_ptr, rd_ptr;
    int unsigned queued_frames;    // buffered, not yet granted
    int unsigned stored_frames;    // physically held, granted or not
    int unsigned phase;
    int unsigned grant_left;
    logic [31:0] frame_on_show;
    bit          call_ok;
    int unsigned limit;
    result_t     expected_results[$];
    int          errors;
    int          n_items, n_checked, n_accepted, n_refused, n_dropped;
    int          n_frames, n_block_ends;

    function new();
      wr_ptr = '0; rd_ptr = '0; queued_frames = 0; stored_frames = 0;
      phase = 0; grant_left = 0; frame_on_show = '0; call_ok = 0;
      limit = 32'(LIMIT_RESET);
      errors = 0; n_items = 0; n_checked = 0; n_accepted = 0; n_refused = 0;
      n_dropped = 0; n_frames = 0; n_block_ends = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = 32'(v);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [31:0] take_frame();
      logic [31:0] f;
      f = frame_mem[rd_ptr];
      rd_ptr = rd_ptr + 13'd1;
      stored_frames--;
      grant_left--;
      return f;
    endfunction

    // Noted at the edge the input transaction is accepted
    function void note_item(item_t it);
      result_t r;
      logic [31:0] f;
      r = '0;
      n_items++;
      if (it.opcode == OP_PUSH) begin
        // admission is decided only on the first frame of a call
        if (it.first_of_call) call_ok = (queued_frames < limit);
        if (!call_ok) begin
          r.status = ST_REFUSED;
          n_refused++;
        end else if (stored_frames >= DEPTH) begin
          r.status = ST_DROPPED;
          n_dropped++;
        end else begin
          frame_mem[wr_ptr] = {it.right_in, it.left_in};
          wr_ptr = wr_ptr + 13'd1;
          stored_frames++;
          queued_frames++;
          r.status = ST_ACCEPTED;
          n_accepted++;
        end
      end else begin
        if (phase == 0) begin
          grant_left = (queued_frames < GRANT_MAX) ? queued_frames : GRANT_MAX;
          queued_frames -= grant_left;
        end
        // floor(2p/3) advances on every phase except p mod 3 == 1
        if (phase % 3 != 1) frame_on_show = (grant_left != 0) ? take_frame() : '0;
        r.status    = ST_FRAME;
        r.left_out  = frame_on_show[15:0];
        r.right_out = frame_on_show[31:16];
        n_frames++;
        if (phase + 1 >= BLOCK_OUT) begin
          r.block_end = 1'b1;
          n_block_ends++;
          phase = 0;
          while (grant_left != 0) f = take_frame();
        end else begin
          phase++;
        end
      end
      r.buffered_frames = queued_frames[BUFFERED_W-1:0];
      expected_results.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result with nothing outstanding", got, 0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.left_out != want.left_out) report("left_out", got.left_out, want.left_out);
        if (got.right_out != want.right_out)
          report("right_out", got.right_out, want.right_out);
        if (got.block_end != want.block_end)
          report("block_end", got.block_end, want.block_end);
        if (got.buffered_frames != want.buffered_frames)
          report("buffered_frames", got.buffered_frames, want.buffered_frames);
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, ports
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [13:0] cfg_data_i    = '0;

  always #5 clk_i = ~clk_i;

  audio_fifo_upsampler_2to3_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  upsampler_scoreboard sb = new();

  int tx_idle_pct  = 0;   // chance in 100 that the sender idles a cycle
  int rx_stall_pct = 0;   // chance in 100 that the receiver stalls a cycle
  int rx_hold      = 0;   // cycles of forced receiver hold-off still to run

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every handshake is taken from pre-edge values at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    item_t   seen_item;
    result_t seen_res;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_limit(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.opcode        = op_e'(s_axis_tuser[0]);
        seen_item.first_of_call = s_axis_tuser[1];
        seen_item.left_in       = s_axis_tdata[15:0];
        seen_item.right_in      = s_axis_tdata[31:16];
        sb.note_item(seen_item);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.status          = status_e'(m_axis_tuser);
        seen_res.left_out        = m_axis_tdata[15:0];
        seen_res.right_out       = m_axis_tdata[31:16];
        seen_res.buffered_frames = m_axis_tdata[45:32];
        seen_res.block_end       = m_axis_tlast;
        sb.check_result(seen_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // One slave transaction; tvalid stays high afterwards unless the next call
  // decides to idle, so back-to-back transactions never toggle it.
  task send_item(op_e op, logic first, logic [15:0] l, logic [15:0] r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {first, op};
    s_axis_tdata  <= {r, l};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly random words, with the sample extremes turning up often
  function logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task push_call(int frames);
    for (int i = 0; i < frames; i++)
      send_item(OP_PUSH, (i == 0), pick_sample(), pick_sample());
  endtask

  task ticks(int n);
    for (int i = 0; i < n; i++)
      send_item(OP_TICK, 1'b0, pick_sample(), pick_sample());
  endtask

  // Stop sending and let the block empty out before touching the limit
  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task write_limit(int unsigned v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[13:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed push calls and tick bursts, with some stray pushes that lean
  // on the previous call's decision and noise with random control bits
  task run_mix(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 12);
          push_call(len);
        end
        4, 5, 6, 7: begin
          len = $urandom_range(1, 40);
          ticks(len);
        end
        8: begin
          len = 1;
          send_item(OP_PUSH, 1'b0, pick_sample(), pick_sample());
        end
        default: begin
          len = 1;
          send_item(op_e'($urandom_range(1)), 1'($urandom_range(1)), pick_sample(),
                    pick_sample());
        end
      endcase
      sent += len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray push straight after reset is refused, an empty block
    // start grants nothing, then a call carrying the sample extremes
    send_item(OP_PUSH, 1'b0, 16'h1234, 16'h5678);
    send_item(OP_TICK, 1'b0, 16'h0000, 16'h0000);
    send_item(OP_PUSH, 1'b1, 16'h7FFF, 16'h8000);
    send_item(OP_PUSH, 1'b0, 16'h8000, 16'h7FFF);
    send_item(OP_PUSH, 1'b0, 16'hFFFF, 16'h0000);
    send_item(OP_PUSH, 1'b0, 16'h0000, 16'hFFFF);
    send_item(OP_PUSH, 1'b0, 16'h5555, 16'hAAAA);
    send_item(OP_PUSH, 1'b0, 16'hAAAA, 16'h5555);
    send_item(OP_TICK, 1'b1, 16'hFFFF, 16'hFFFF);
    send_item(OP_TICK, 1'b0, 16'h0000, 16'h0000);
    // limit of zero refuses everything, including the calls' stray frames
    write_limit(0);
    send_item(OP_PUSH, 1'b1, 16'h0001, 16'h0002);
    send_item(OP_PUSH, 1'b0, 16'h0003, 16'h0004);
    // a limit equal to the FIFO depth admits
    write_limit(LIMIT_MAX);
    send_item(OP_PUSH, 1'b1, 16'h8001, 16'h7FFE);
    send_item(OP_PUSH, 1'b0, 16'h4000, 16'hC000);
    // limit right at the buffered count refuses the next call
    write_limit(8);
    send_item(OP_PUSH, 1'b1, 16'h1111, 16'h2222);
    send_item(OP_PUSH, 1'b0, 16'h3333, 16'h4444);
    write_limit(9);
    send_item(OP_PUSH, 1'b1, 16'h5555, 16'h6666);
    send_item(OP_PUSH, 1'b0, 16'h7777, 16'h8888);

    // Random: four idling regimes, each under its own admission limit
    write_limit(40);
    tx_idle_pct = 0;  rx_stall_pct = 0;
    run_mix(150);
    write_limit(300);
    tx_idle_pct = 88; rx_stall_pct = 0;
    run_mix(150);
    write_limit($urandom_range(1, 500));
    tx_idle_pct = 0;  rx_stall_pct = 88;
    run_mix(150);
    write_limit(120);
    tx_idle_pct = 35; rx_stall_pct = 35;
    run_mix(140);

    // Back-pressure: receiver held off while the sender keeps offering
    write_limit(32'(LIMIT_RESET));
    tx_idle_pct = 0;  rx_stall_pct = 0;
    rx_hold = 400;
    run_mix(130);

    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d transactions in and %0d checked out", sb.n_items,
             sb.n_checked);
    $display("  %0d accepted, %0d refused, %0d dropped, %0d output frames, %0d block ends",
             sb.n_accepted, sb.n_refused, sb.n_dropped, sb.n_frames, sb.n_block_ends);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, well clear of the slowest legal run
  initial begin
    #5_000_000;
    $display("watchdog expired with %0d results outstanding", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
